// ===== sv/hslca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslca_pkg
// shared types for the hsl color adjust pipeline
// ----------------------------------------------------------------------------
package hslca_pkg;

  // which channel holds the maximum, ties resolved red first, then green
  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_t;

endpackage

// ===== sv/hslca_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslca_in_if / hslca_out_if
// valid/ready channels for pixel requests and adjusted pixels
// ----------------------------------------------------------------------------
interface hslca_in_if #(parameter int FRAC_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [FRAC_BITS:0]     red_in;
  logic [FRAC_BITS:0]     green_in;
  logic [FRAC_BITS:0]     blue_in;
  logic [FRAC_BITS:0]     alpha_in;
  logic signed [FRAC_BITS+1:0] hue_delta;
  logic signed [FRAC_BITS+1:0] sat_delta;
  logic signed [FRAC_BITS+1:0] light_delta;

  modport source (output valid, red_in, green_in, blue_in, alpha_in,
                  hue_delta, sat_delta, light_delta, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in,
                  hue_delta, sat_delta, light_delta, output ready);
endinterface

interface hslca_out_if #(parameter int FRAC_BITS = 12);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] red_out;
  logic [FRAC_BITS:0] green_out;
  logic [FRAC_BITS:0] blue_out;
  logic [FRAC_BITS:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ===== sv/hslca_rgb2hsl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslca_rgb2hsl
// input clamping, max/min search and divider operand setup (two stages)
// ----------------------------------------------------------------------------
module hslca_rgb2hsl #(
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [FRAC_BITS:0]          red,
  input  logic [FRAC_BITS:0]          green,
  input  logic [FRAC_BITS:0]          blue,
  input  logic signed [FRAC_BITS+1:0] hue_d,
  input  logic signed [FRAC_BITS+1:0] sat_d,
  input  logic signed [FRAC_BITS+1:0] light_d,
  output logic [FRAC_BITS:0]          num_s,
  output logic [FRAC_BITS+1:0]        den_s,
  output logic [FRAC_BITS:0]          num_h,
  output logic [FRAC_BITS+1:0]        den_h,
  output hslca_pkg::sector_t          sector,
  output logic                        neg,
  output logic                        eq,
  output logic [FRAC_BITS:0]          light,
  output logic signed [FRAC_BITS+1:0] hue_dc,
  output logic signed [FRAC_BITS+1:0] sat_dc,
  output logic signed [FRAC_BITS+1:0] light_dc
);
  localparam int CW = FRAC_BITS + 1;
  localparam int DW = FRAC_BITS + 2;
  localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CW:0] TWO_ONE = {2'b10, {FRAC_BITS{1'b0}}};
  localparam logic signed [DW-1:0] D_POS = {1'b0, ONE};
  localparam logic signed [DW-1:0] D_NEG = -D_POS;

  logic [CW-1:0] r0_r, g0_r, b0_r;
  logic signed [DW-1:0] hd0_r, sd0_r, ld0_r;

  function automatic logic signed [DW-1:0] clamp_d(input logic signed [DW-1:0] v);
    if (v > D_POS) return D_POS;
    if (v < D_NEG) return D_NEG;
    return v;
  endfunction

  // stage 0: saturate channels and deltas
  always_ff @(posedge clk) begin
    if (en) begin
      r0_r  <= (red   > ONE) ? ONE : red;
      g0_r  <= (green > ONE) ? ONE : green;
      b0_r  <= (blue  > ONE) ? ONE : blue;
      hd0_r <= clamp_d(hue_d);
      sd0_r <= clamp_d(sat_d);
      ld0_r <= clamp_d(light_d);
    end
  end

  // stage 1: max/min, lightness, divider operands
  hslca_pkg::sector_t sec_c;
  logic [CW-1:0] mx, mn, d, diff;
  logic [CW:0]   sum;
  logic          neg_c, big;

  always_comb begin
    if (r0_r >= g0_r && r0_r >= b0_r) begin
      sec_c = hslca_pkg::SEC_RED;
      mx    = r0_r;
      neg_c = g0_r < b0_r;
      diff  = neg_c ? b0_r - g0_r : g0_r - b0_r;
    end else if (g0_r >= b0_r) begin
      sec_c = hslca_pkg::SEC_GREEN;
      mx    = g0_r;
      neg_c = b0_r < r0_r;
      diff  = neg_c ? r0_r - b0_r : b0_r - r0_r;
    end else begin
      sec_c = hslca_pkg::SEC_BLUE;
      mx    = b0_r;
      neg_c = r0_r < g0_r;
      diff  = neg_c ? g0_r - r0_r : r0_r - g0_r;
    end
    mn = r0_r;
    if (g0_r < mn) mn = g0_r;
    if (b0_r < mn) mn = b0_r;
    sum = {1'b0, mx} + {1'b0, mn};
    d   = mx - mn;
    big = {sum[CW:1], 1'b0} > {1'b0, ONE};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_s    <= d;
      den_s    <= big ? TWO_ONE - sum : sum;
      num_h    <= diff;
      den_h    <= {1'b0, d};
      sector   <= sec_c;
      neg      <= neg_c;
      eq       <= (mx == mn);
      light    <= sum[CW:1];
      hue_dc   <= hd0_r;
      sat_dc   <= sd0_r;
      light_dc <= ld0_r;
    end
  end

endmodule

// ===== sv/hslca_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslca_div
// two-lane pipelined restoring divider, num*ONE/den, one quotient bit a stage
// ----------------------------------------------------------------------------
module hslca_div #(
  parameter int FRAC_BITS = 12,
  parameter int TAG_W     = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS:0]   num [2],
  input  logic [FRAC_BITS+1:0] den [2],
  input  logic [TAG_W-1:0]     tag_in,
  output logic [FRAC_BITS:0]   quo [2],
  output logic [TAG_W-1:0]     tag_out
);
  localparam int N  = FRAC_BITS + 1;
  localparam int RW = FRAC_BITS + 2;

  logic [RW-1:0]    rem_r [N][2];
  logic [RW-1:0]    den_r [N][2];
  logic [N-1:0]     quo_r [N][2];
  logic [TAG_W-1:0] tag_r [N];
  logic             ge0 [2];

  // first stage: the integer bit of the quotient
  always_comb begin
    for (int l = 0; l < 2; l++) ge0[l] = {1'b0, num[l]} >= den[l];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= tag_in;
      for (int l = 0; l < 2; l++) begin
        den_r[0][l] <= den[l];
        rem_r[0][l] <= ge0[l] ? {1'b0, num[l]} - den[l] : {1'b0, num[l]};
        quo_r[0][l] <= {ge0[l], {FRAC_BITS{1'b0}}};
      end
    end
  end

  for (genvar i = 1; i < N; i++) begin : g_stage
    logic [RW:0] two [2];
    logic        ge  [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        two[l] = {rem_r[i-1][l], 1'b0};
        ge[l]  = two[l] >= {1'b0, den_r[i-1][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[i] <= tag_r[i-1];
        for (int l = 0; l < 2; l++) begin
          den_r[i][l] <= den_r[i-1][l];
          rem_r[i][l] <= ge[l] ? RW'(two[l] - {1'b0, den_r[i-1][l]}) : two[l][RW-1:0];
          quo_r[i][l] <= quo_r[i-1][l] | (N'(ge[l]) << (N - 1 - i));
        end
      end
    end
  end

  assign quo[0]  = quo_r[N-1][0];
  assign quo[1]  = quo_r[N-1][1];
  assign tag_out = tag_r[N-1];

endmodule

// ===== sv/hslca_adjust.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslca_adjust
// hue assembly and shift, saturation/lightness moves, q and p (four stages)
// ----------------------------------------------------------------------------
module hslca_adjust #(
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [FRAC_BITS:0]          quo_s,
  input  logic [FRAC_BITS:0]          quo_h,
  input  hslca_pkg::sector_t          sector,
  input  logic                        neg,
  input  logic                        eq,
  input  logic [FRAC_BITS:0]          light,
  input  logic signed [FRAC_BITS+1:0] hue_d,
  input  logic signed [FRAC_BITS+1:0] sat_d,
  input  logic signed [FRAC_BITS+1:0] light_d,
  output logic [FRAC_BITS-1:0]        hue,
  output logic [FRAC_BITS:0]          q,
  output logic [FRAC_BITS:0]          p,
  output logic [FRAC_BITS:0]          light_o,
  output logic                        s_zero
);
  localparam int CW  = FRAC_BITS + 1;
  localparam int DW  = FRAC_BITS + 2;
  localparam int H6W = FRAC_BITS + 3;
  localparam int XW  = FRAC_BITS + 2;
  localparam int SH  = XW + 2;
  localparam int MW  = XW + SH;
  localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / 3);
  localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [H6W-1:0] ONE6 = {3'b000, ONE[FRAC_BITS-1:0]} | (H6W'(1) << FRAC_BITS);

  // stage A: sector base plus or minus the fraction, delta products
  logic [H6W-1:0] base, h6;
  logic [CW-1:0]  s_c, sfac, lfac, smag, lmag;
  logic signed [DW-1:0] nsd, nld;
  logic           spos, lpos;

  always_comb begin
    case (sector)
      hslca_pkg::SEC_RED:   base = neg ? H6W'(ONE6 * 6) : '0;
      hslca_pkg::SEC_GREEN: base = H6W'(ONE6 * 2);
      hslca_pkg::SEC_BLUE:  base = H6W'(ONE6 * 4);
      default:              base = '0;
    endcase
    h6   = neg ? base - H6W'(quo_h) : base + H6W'(quo_h);
    if (eq) h6 = '0;
    s_c  = eq ? '0 : quo_s;
    nsd  = -sat_d;
    nld  = -light_d;
    spos = sat_d > 0;
    lpos = light_d > 0;
    smag = spos ? sat_d[CW-1:0] : nsd[CW-1:0];
    lmag = lpos ? light_d[CW-1:0] : nld[CW-1:0];
    sfac = spos ? ONE - s_c : s_c;
    lfac = lpos ? ONE - light : light;
  end

  logic [XW-1:0]        xa_r;
  logic signed [DW-1:0] hd_a_r;
  logic [CW-1:0]        s_a_r, l_a_r;
  logic                 spos_a_r, lpos_a_r;
  logic [2*CW-1:0]      sprod_a_r, lprod_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r      <= h6[H6W-1:1];
      hd_a_r    <= hue_d;
      s_a_r     <= s_c;
      l_a_r     <= light;
      spos_a_r  <= spos;
      lpos_a_r  <= lpos;
      sprod_a_r <= sfac * smag;
      lprod_a_r <= lfac * lmag;
    end
  end

  // stage B: reciprocal product for the divide by three, finish the moves
  logic [CW-1:0] sstep, lstep;
  assign sstep = sprod_a_r[FRAC_BITS +: CW];
  assign lstep = lprod_a_r[FRAC_BITS +: CW];

  logic [XW-1:0]        xb_r;
  logic [MW-1:0]        xmb_r;
  logic signed [DW-1:0] hd_b_r;
  logic [CW-1:0]        s_b_r, l_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xb_r   <= xa_r;
      xmb_r  <= xa_r * RECIP;
      hd_b_r <= hd_a_r;
      s_b_r  <= spos_a_r ? s_a_r + sstep : s_a_r - sstep;
      l_b_r  <= lpos_a_r ? l_a_r + lstep : l_a_r - lstep;
    end
  end

  // stage C: correct the quotient, add half the hue delta and wrap
  logic [CW-1:0]         q3, h0;
  logic [XW-1:0]         rem3;
  logic [DW-1:0]         hd_adj;
  logic signed [DW-1:0]  hh;
  logic signed [H6W-1:0] hsum;
  logic [FRAC_BITS-1:0]  hw;
  logic                  lt;
  logic [CW:0]           mfac;

  always_comb begin
    q3     = xmb_r[SH +: CW];
    rem3   = xb_r - XW'({q3, 1'b0} + q3);
    h0     = (rem3 >= XW'(3)) ? q3 + 1'b1 : q3;
    hd_adj = hd_b_r + DW'(hd_b_r[DW-1]);
    hh     = $signed(hd_adj) >>> 1;
    hsum   = $signed({2'b00, h0}) + H6W'(hh);
    if (hsum < 0)
      hw = FRAC_BITS'(hsum + $signed({2'b00, ONE}));
    else if (hsum >= $signed({2'b00, ONE}))
      hw = FRAC_BITS'(hsum - $signed({2'b00, ONE}));
    else
      hw = hsum[FRAC_BITS-1:0];
    lt   = {l_b_r, 1'b0} < {1'b0, ONE};
    mfac = lt ? {1'b0, ONE} + {1'b0, s_b_r} : {1'b0, s_b_r};
  end

  logic [FRAC_BITS-1:0] h_c_r;
  logic [2*CW:0]        lprod_c_r;
  logic [CW-1:0]        l_c_r, s_c_r;
  logic                 lt_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h_c_r     <= hw;
      lprod_c_r <= l_b_r * mfac;
      l_c_r     <= l_b_r;
      s_c_r     <= s_b_r;
      lt_c_r    <= lt;
    end
  end

  // stage D: q and p
  logic [CW:0] pshift, qv;
  always_comb begin
    pshift = lprod_c_r[FRAC_BITS +: CW+1];
    qv     = lt_c_r ? pshift : {1'b0, l_c_r} + {1'b0, s_c_r} - pshift;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue     <= h_c_r;
      q       <= qv[CW-1:0];
      p       <= CW'({l_c_r, 1'b0} - qv);
      light_o <= l_c_r;
      s_zero  <= (s_c_r == '0);
    end
  end

endmodule

// ===== sv/hslca_hsl2rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslca_hsl2rgb
// per-channel hue ramp back to rgb (three stages)
// ----------------------------------------------------------------------------
module hslca_hsl2rgb #(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] hue,
  input  logic [FRAC_BITS:0]   q,
  input  logic [FRAC_BITS:0]   p,
  input  logic [FRAC_BITS:0]   light,
  input  logic                 s_zero,
  output logic [FRAC_BITS:0]   red,
  output logic [FRAC_BITS:0]   green,
  output logic [FRAC_BITS:0]   blue
);
  localparam int CW = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 4;
  localparam logic [CW-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CW-1:0] THIRD = CW'(ONE / 3);
  localparam logic [TW-1:0] ONE_T = TW'(ONE);

  typedef enum logic [3:0] {
    RG_RISE = 4'b0001,
    RG_TOP  = 4'b0010,
    RG_FALL = 4'b0100,
    RG_LOW  = 4'b1000
  } region_t;

  // stage E: channel phase, region and ramp factor
  logic [CW-1:0] t [3];
  logic [CW:0]   tr;
  logic [TW-1:0] six_t, three_t;
  region_t       rg [3];
  logic [CW-1:0] fac [3];

  always_comb begin
    tr   = {2'b00, hue} + {1'b0, THIRD};
    t[0] = (tr > {1'b0, ONE}) ? CW'(tr - {1'b0, ONE}) : tr[CW-1:0];
    t[1] = {1'b0, hue};
    t[2] = ({1'b0, hue} >= THIRD) ? {1'b0, hue} - THIRD : {1'b0, hue} + ONE - THIRD;
    for (int c = 0; c < 3; c++) begin
      six_t   = (TW'(t[c]) << 2) + (TW'(t[c]) << 1);
      three_t = (TW'(t[c]) << 1) + TW'(t[c]);
      if (six_t < ONE_T) begin
        rg[c]  = RG_RISE;
        fac[c] = six_t[CW-1:0];
      end else if ((TW'(t[c]) << 1) < ONE_T) begin
        rg[c]  = RG_TOP;
        fac[c] = '0;
      end else if (three_t < (ONE_T << 1)) begin
        rg[c]  = RG_FALL;
        fac[c] = CW'((ONE_T << 2) - six_t);
      end else begin
        rg[c]  = RG_LOW;
        fac[c] = '0;
      end
    end
  end

  region_t       rg_e_r  [3];
  logic [CW-1:0] fac_e_r [3];
  logic [CW-1:0] q_e_r, p_e_r, l_e_r;
  logic          sz_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rg_e_r[c]  <= rg[c];
        fac_e_r[c] <= fac[c];
      end
      q_e_r  <= q;
      p_e_r  <= p;
      l_e_r  <= light;
      sz_e_r <= s_zero;
    end
  end

  // stage F: ramp products
  logic [2*CW-1:0] prod_f_r [3];
  region_t         rg_f_r   [3];
  logic [CW-1:0]   q_f_r, p_f_r, l_f_r;
  logic            sz_f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod_f_r[c] <= (q_e_r - p_e_r) * fac_e_r[c];
        rg_f_r[c]   <= rg_e_r[c];
      end
      q_f_r  <= q_e_r;
      p_f_r  <= p_e_r;
      l_f_r  <= l_e_r;
      sz_f_r <= sz_e_r;
    end
  end

  // stage G: pick the channel value, gray when saturation is zero
  logic [CW-1:0] val [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (rg_f_r[c])
        RG_RISE, RG_FALL: val[c] = p_f_r + prod_f_r[c][FRAC_BITS +: CW];
        RG_TOP:           val[c] = q_f_r;
        default:          val[c] = p_f_r;
      endcase
      if (sz_f_r) val[c] = l_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= val[0];
      green <= val[1];
      blue  <= val[2];
    end
  end

endmodule

// ===== sv/hsl_color_adjust_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_color_adjust_top
// rgba pixel hue/saturation/lightness adjust, fully pipelined
// ----------------------------------------------------------------------------
// Takes one pixel request per clock while out_pix is not stalled and
// returns one adjusted pixel per request, in order. At its core is the
// two-lane restoring divider, which resolves one quotient bit per stage
// (FRAC_BITS + 1 stages) for the saturation and hue fractions; two front
// stages and seven back stages surround it. The whole pipeline advances
// together and freezes while a finished pixel waits on out_pix.ready, so
// in_pix.ready drops only in that case. Alpha rides a delay line untouched.
// ----------------------------------------------------------------------------
module hsl_color_adjust_top #(
  parameter int FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  hslca_in_if.sink    in_pix,
  hslca_out_if.source out_pix
);
  localparam int CW    = FRAC_BITS + 1;
  localparam int DW    = FRAC_BITS + 2;
  localparam int N_DIV = FRAC_BITS + 1;
  // front 2, divider, adjust 4, back conversion 3
  localparam int LAT   = 2 + N_DIV + 4 + 3;

  // sideband that rides alongside the divider
  typedef struct packed {
    hslca_pkg::sector_t   sector;
    logic                 neg;
    logic                 eq;
    logic [CW-1:0]        light;
    logic signed [DW-1:0] hue_d;
    logic signed [DW-1:0] sat_d;
    logic signed [DW-1:0] light_d;
  } side_t;

  // global advance: hold everything while the output is stalled
  logic en;
  assign en           = !(out_pix.valid && !out_pix.ready);
  assign in_pix.ready = en;

  // valid bits and alpha travel with the data
  logic [LAT-1:0] vld_r;
  logic [CW-1:0]  alpha_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_pix.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r[0] <= in_pix.alpha_in;
      for (int i = 1; i < LAT; i++) alpha_r[i] <= alpha_r[i-1];
    end
  end

  // rgb to hsl operand setup
  logic [CW-1:0] num_div [2];
  logic [DW-1:0] den_div [2];
  logic [CW-1:0] quo_div [2];
  side_t         side_in, side_out;

  hslca_rgb2hsl #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .en       (en),
    .red      (in_pix.red_in),
    .green    (in_pix.green_in),
    .blue     (in_pix.blue_in),
    .hue_d    (in_pix.hue_delta),
    .sat_d    (in_pix.sat_delta),
    .light_d  (in_pix.light_delta),
    .num_s    (num_div[0]),
    .den_s    (den_div[0]),
    .num_h    (num_div[1]),
    .den_h    (den_div[1]),
    .sector   (side_in.sector),
    .neg      (side_in.neg),
    .eq       (side_in.eq),
    .light    (side_in.light),
    .hue_dc   (side_in.hue_d),
    .sat_dc   (side_in.sat_d),
    .light_dc (side_in.light_d)
  );

  // lane 0: saturation, lane 1: hue fraction within the sector
  hslca_div #(.FRAC_BITS(FRAC_BITS), .TAG_W($bits(side_t))) u_div (
    .clk     (clk),
    .en      (en),
    .num     (num_div),
    .den     (den_div),
    .tag_in  (side_in),
    .quo     (quo_div),
    .tag_out (side_out)
  );

  logic [FRAC_BITS-1:0] hue_a;
  logic [CW-1:0]        q_a, p_a, l_a;
  logic                 sz_a;

  hslca_adjust #(.FRAC_BITS(FRAC_BITS)) u_adjust (
    .clk     (clk),
    .en      (en),
    .quo_s   (quo_div[0]),
    .quo_h   (quo_div[1]),
    .sector  (side_out.sector),
    .neg     (side_out.neg),
    .eq      (side_out.eq),
    .light   (side_out.light),
    .hue_d   (side_out.hue_d),
    .sat_d   (side_out.sat_d),
    .light_d (side_out.light_d),
    .hue     (hue_a),
    .q       (q_a),
    .p       (p_a),
    .light_o (l_a),
    .s_zero  (sz_a)
  );

  // back to rgb, lands in the output register
  hslca_hsl2rgb #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk    (clk),
    .en     (en),
    .hue    (hue_a),
    .q      (q_a),
    .p      (p_a),
    .light  (l_a),
    .s_zero (sz_a),
    .red    (out_pix.red_out),
    .green  (out_pix.green_out),
    .blue   (out_pix.blue_out)
  );

  assign out_pix.valid     = vld_r[LAT-1];
  assign out_pix.alpha_out = alpha_r[LAT-1];

endmodule

// ===== sv/hslca_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslca_assertions
// port-level checks for the hsl color adjust pipeline
// ----------------------------------------------------------------------------
module hslca_assertions #(
  parameter int FRAC_BITS = 12
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FRAC_BITS:0] red_out,
  input logic [FRAC_BITS:0] green_out,
  input logic [FRAC_BITS:0] blue_out
);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // a waiting result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // requests are refused exactly while a result is stalled
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !(out_valid && !out_ready))
    else $error("input ready does not follow output stall");

  // adjusted channels never exceed one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (red_out <= ONE && green_out <= ONE && blue_out <= ONE))
    else $error("channel out of range");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind hsl_color_adjust_top hslca_assertions #(.FRAC_BITS(FRAC_BITS)) u_hslca_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .red_out   (out_pix.red_out),
  .green_out (out_pix.green_out),
  .blue_out  (out_pix.blue_out)
);

// ===== bench/hslca_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslca_checker
// watches both pixel channels, predicts each adjusted pixel and compares
// ----------------------------------------------------------------------------
module hslca_checker #(
  parameter int FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  hslca_in_if.sink    in_mon,
  hslca_out_if.sink   out_mon,
  output int          fail_count,
  output int          pending
);

  localparam longint ONE = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic [FRAC_BITS:0] red;
    logic [FRAC_BITS:0] green;
    logic [FRAC_BITS:0] blue;
    logic [FRAC_BITS:0] alpha;
  } pixel_t;

  pixel_t adjusted_q[$];

  function automatic longint sat_chan(logic [FRAC_BITS:0] v);
    return (longint'(v) > ONE) ? ONE : longint'(v);
  endfunction

  function automatic longint sat_delta(logic signed [FRAC_BITS+1:0] v);
    longint d;
    d = longint'(v);
    if (d > ONE) d = ONE;
    if (d < -ONE) d = -ONE;
    return d;
  endfunction

  function automatic longint nudge(longint x, longint d);
    if (d > 0) return x + ((ONE - x) * d) / ONE;
    return x - (x * (-d)) / ONE;
  endfunction

  function automatic longint hue_to_chan(longint p, longint q, longint t);
    if (t < 0) t += ONE;
    if (t > ONE) t -= ONE;
    if (6 * t < ONE) return p + ((q - p) * 6 * t) / ONE;
    if (2 * t < ONE) return q;
    if (3 * t < 2 * ONE) return p + ((q - p) * (4 * ONE - 6 * t)) / ONE;
    return p;
  endfunction

  function automatic logic [FRAC_BITS:0] out_clip(longint v);
    if (v < 0) v = 0;
    if (v > ONE) v = ONE;
    return v[FRAC_BITS:0];
  endfunction

  function automatic pixel_t adjust_pixel(logic [FRAC_BITS:0] ri, gi, bi, ai,
                                          logic signed [FRAC_BITS+1:0] hdi, sdi, ldi);
    longint r, g, b, hd, sd, ld, mx, mn, sum, h, s, l, d, h6, q, p, third;
    pixel_t px;
    r = sat_chan(ri); g = sat_chan(gi); b = sat_chan(bi);
    hd = sat_delta(hdi); sd = sat_delta(sdi); ld = sat_delta(ldi);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = mx + mn;
    l = sum / 2;
    if (mx == mn) begin
      h = 0; s = 0;
    end else begin
      d = mx - mn;
      if (2 * l > ONE) s = (d * ONE) / (2 * ONE - sum);
      else s = (d * ONE) / sum;
      if (mx == r) begin
        if (g >= b) h6 = ((g - b) * ONE) / d;
        else h6 = 6 * ONE - ((b - g) * ONE) / d;
      end else if (mx == g) begin
        if (b >= r) h6 = 2 * ONE + ((b - r) * ONE) / d;
        else h6 = 2 * ONE - ((r - b) * ONE) / d;
      end else begin
        if (r >= g) h6 = 4 * ONE + ((r - g) * ONE) / d;
        else h6 = 4 * ONE - ((g - r) * ONE) / d;
      end
      h = h6 / 6;
    end
    h += hd / 2;
    if (h < 0) h += ONE;
    else if (h >= ONE) h -= ONE;
    s = nudge(s, sd);
    l = nudge(l, ld);
    if (s == 0) begin
      r = l; g = l; b = l;
    end else begin
      third = ONE / 3;
      if (2 * l < ONE) q = (l * (ONE + s)) / ONE;
      else q = l + s - (l * s) / ONE;
      p = 2 * l - q;
      r = hue_to_chan(p, q, h + third);
      g = hue_to_chan(p, q, h);
      b = hue_to_chan(p, q, h - third);
    end
    px.red = out_clip(r); px.green = out_clip(g); px.blue = out_clip(b);
    px.alpha = ai;
    return px;
  endfunction

  assign pending = adjusted_q.size();

  always @(posedge clk) begin
    pixel_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        adjusted_q.push_back(adjust_pixel(in_mon.red_in, in_mon.green_in, in_mon.blue_in,
          in_mon.alpha_in, in_mon.hue_delta, in_mon.sat_delta, in_mon.light_delta));
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.red_out, out_mon.green_out, out_mon.blue_out, out_mon.alpha_out};
        if (adjusted_q.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = adjusted_q.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha) begin
            $display("%0t: mismatch, expected r=%0d g=%0d b=%0d a=%0d, actual r=%0d g=%0d b=%0d a=%0d",
              $time, want.red, want.green, want.blue, want.alpha,
              got.red, got.green, got.blue, got.alpha);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/hsl_color_adjust_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_color_adjust_top_tb
// drives pixel requests with random idling and back-pressure; checker
// predicts and compares every adjusted pixel
// ----------------------------------------------------------------------------
module hsl_color_adjust_top_tb;

  localparam int FB = 12;
  localparam int ONE = 1 << FB;
  localparam int N_RANDOM = 1030;
  localparam int CALM_FROM = 900;     // no idling past this request
  localparam int LIMIT = 400000;

  logic clk, rst_n;
  int   fail_count, pending, cycles;
  int   sent;

  hslca_in_if  #(.FRAC_BITS(FB)) in_pix ();
  hslca_out_if #(.FRAC_BITS(FB)) out_pix ();

  hsl_color_adjust_top #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix.sink), .out_pix(out_pix.source)
  );

  hslca_checker #(.FRAC_BITS(FB)) chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_pix.sink), .out_mon(out_pix.sink),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // cycle counter, ends a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // pick a channel value: extremes often, sometimes above one
  function automatic logic [FB:0] pick_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return (FB+1)'(ONE);
      2: return (FB+1)'($urandom_range(ONE + 1, 2 * ONE - 1));
      default: return (FB+1)'($urandom_range(0, ONE));
    endcase
  endfunction

  function automatic logic signed [FB+1:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return (FB+2)'(ONE);
      2: return (FB+2)'(-ONE);
      3: return (FB+2)'($urandom());    // full 14 bit range, incl. beyond +-one
      default: return (FB+2)'(int'($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  // hold one request on the channel until it is taken
  task automatic send_pixel(logic [FB:0] r, g, b, a, logic signed [FB+1:0] hd, sd, ld);
    in_pix.valid <= 1'b1;
    in_pix.red_in <= r; in_pix.green_in <= g; in_pix.blue_in <= b;
    in_pix.alpha_in <= a;
    in_pix.hue_delta <= hd; in_pix.sat_delta <= sd; in_pix.light_delta <= ld;
    do @(posedge clk); while (!in_pix.ready);
    @(negedge clk);
    sent++;
    // random idle burst between requests, none near the end
    if (sent < CALM_FROM && $urandom_range(0, 5) == 0) begin
      in_pix.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // receiver: random stalls, one long hold-off so the pipe fills and stalls input
  initial begin
    out_pix.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    out_pix.ready <= 1'b1;
    wait (sent >= 40);
    @(negedge clk);
    out_pix.ready <= 1'b0;
    repeat (120) @(negedge clk);
    out_pix.ready <= 1'b1;
    while (sent < CALM_FROM) begin
      @(negedge clk);
      if ($urandom_range(0, 7) == 0) begin
        out_pix.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_pix.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [FB:0] v;
    sent = 0;
    rst_n = 1'b0;
    in_pix.valid = 1'b0;
    in_pix.red_in = '0; in_pix.green_in = '0; in_pix.blue_in = '0;
    in_pix.alpha_in = '0;
    in_pix.hue_delta = '0; in_pix.sat_delta = '0; in_pix.light_delta = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: gray, extremes, ties, channels above one, delta saturation
    send_pixel(0, 0, 0, 0, 0, 0, 0);
    send_pixel(ONE, ONE, ONE, ONE, 0, 0, 0);
    send_pixel(2048, 2048, 2048, 8191, 4096, 4096, 0);
    send_pixel(ONE, 0, 0, ONE, 0, 0, 0);
    send_pixel(0, ONE, 0, 100, 0, 0, 0);
    send_pixel(0, 0, ONE, 200, 0, 0, 0);
    send_pixel(ONE, ONE, 0, 1, 0, 0, 0);          // red/green tie
    send_pixel(0, ONE, ONE, 2, 0, 0, 0);          // green/blue tie
    send_pixel(ONE, 0, ONE, 3, 0, 0, 0);          // red/blue tie
    send_pixel(8191, 8191, 8191, 8191, 0, 0, 0);  // above one
    send_pixel(8191, 0, 5000, 0, 8191, 8191, 8191);
    send_pixel(3000, 1000, 500, 7, -8192, -8192, -8192);
    send_pixel(1000, 3000, 500, 9, 4096, -4096, 4096);
    send_pixel(500, 1000, 3000, 11, -4096, 4096, -4096);
    send_pixel(3000, 500, 1000, 13, 1, -1, 1);
    send_pixel(1000, 500, 3000, 15, -1, 1, -1);
    send_pixel(4096, 4095, 4094, 17, 8191, 0, -1);
    send_pixel(1, 0, 0, 19, 0, 0, 4096);

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        v = pick_chan();
        send_pixel(v, v, v, (FB+1)'($urandom()), pick_delta(), pick_delta(), pick_delta());
      end else begin
        send_pixel(pick_chan(), pick_chan(), pick_chan(), (FB+1)'($urandom()),
                   pick_delta(), pick_delta(), pick_delta());
      end
    end
    in_pix.valid <= 1'b0;

    wait (pending == 0);
    repeat (FB + 20) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
